// ===== hw/rtl/isad_pkg.sv =====
// shared types and constants for the insertion sorter
// no dependencies; used by isad_cell, insertion_sorter_asc_desc, isad_checker and the testbench
package isad_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic ins;        // insert the key this cycle
        logic shl;        // shift the whole row one place toward cell 0
        logic ascending;  // order used for the compare
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/insertion_sorter_asc_desc.sv =====
// insertion sorter top level: row of isad_cell, input and output streams
// depends on isad_pkg and isad_cell
//
// usage
//   s_axis carries one signed 32-bit value per transfer, s_axis_tlast closes a set.
//   each value is placed into a row of CAPACITY cells: every cell compares against
//   the key and the entries behind the insertion point move one cell toward the
//   tail, so a value can be taken in every cycle while filling.
//   after the transfer carrying tlast the row drains through m_axis one entry per
//   cycle while m_axis_tready is high, cell 0 first; m_axis_tlast marks the final
//   entry, m_axis_tuser[0] is set on every result of a set that lost values to a
//   full row. the tlast transfer sets the drain flag, and the first result is then
//   loaded into the output register; s_axis_tready stays low from the tlast transfer
//   until the final entry of the set has been loaded into the output register.
//   cfg_wr_en writes cfg_wr_data as the order bit (1 smallest first, 0 largest
//   first); it is used for each value at the time it is inserted.
//   reset empties the row, clears the overflow flag and selects ascending order.
//   a stall on m_axis holds the output register and pauses the drain; values that
//   arrive while the row is full are dropped.
module insertion_sorter_asc_desc
    import isad_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,   // sort_ascending
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // value
    input  logic              s_axis_tlast,  // last_in
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // sorted_value
    output logic              m_axis_tlast,  // last_out
    output logic [7:0]        m_axis_tuser   // [0] overflowed, rest zero
);

    data_t      cell_val   [CAPACITY+1];
    logic       cell_valid [CAPACITY+1];
    logic       cell_move  [CAPACITY+1];
    cell_ctrl_t ctrl;
    data_t      key;

    logic  asc_reg;
    logic  drain_reg,     drain_next;
    logic  ovf_seen_reg,  ovf_seen_next;
    logic  ovf_frame_reg, ovf_frame_next;
    logic  m_valid_reg,   m_valid_next;
    data_t m_data_reg,    m_data_next;
    logic  m_last_reg,    m_last_next;
    logic  m_user_reg,    m_user_next;

    logic  in_xfer;
    logic  full;
    logic  load_out;

    assign key     = data_t'(s_axis_tdata);
    assign full    = cell_valid[CAPACITY-1];
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign load_out = drain_reg && (!m_valid_reg || m_axis_tready);

    assign ctrl.ins       = in_xfer && !full;
    assign ctrl.shl       = load_out;
    assign ctrl.ascending = asc_reg;

    // tail of the row: nothing behind the last cell
    assign cell_val[CAPACITY]   = '0;
    assign cell_valid[CAPACITY] = 1'b0;
    assign cell_move[CAPACITY]  = 1'b1;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            isad_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .key         (key),
                .left_val    (key),
                .left_valid  (1'b1),
                .left_move   (1'b0),
                .right_val   (cell_val[i+1]),
                .right_valid (cell_valid[i+1]),
                .right_move  (cell_move[i+1]),
                .val         (cell_val[i]),
                .valid       (cell_valid[i]),
                .move        (cell_move[i])
            );
        end
        else
        begin : g_body
            isad_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .key         (key),
                .left_val    (cell_val[i-1]),
                .left_valid  (cell_valid[i-1]),
                .left_move   (cell_move[i-1]),
                .right_val   (cell_val[i+1]),
                .right_valid (cell_valid[i+1]),
                .right_move  (cell_move[i+1]),
                .val         (cell_val[i]),
                .valid       (cell_valid[i]),
                .move        (cell_move[i])
            );
        end
    end

    always_comb
    begin
        drain_next     = drain_reg;
        ovf_seen_next  = ovf_seen_reg;
        ovf_frame_next = ovf_frame_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (in_xfer)
        begin
            if (s_axis_tlast)
            begin
                drain_next     = 1'b1;
                ovf_frame_next = ovf_seen_reg | full;
                ovf_seen_next  = 1'b0;
            end
            else if (full)
            begin
                ovf_seen_next = 1'b1;
            end
        end

        if (load_out)
        begin
            m_valid_next = 1'b1;
            m_data_next  = cell_val[0];
            m_last_next  = !cell_valid[1];
            m_user_next  = ovf_frame_reg;
            if (!cell_valid[1])
            begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asc_reg      <= 1'b1;
            drain_reg    <= 1'b0;
            ovf_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                asc_reg <= cfg_wr_data;
            end
            drain_reg    <= drain_next;
            ovf_seen_reg <= ovf_seen_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_frame_reg <= ovf_frame_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        m_user_reg    <= m_user_next;
    end

    assign s_axis_tready = !drain_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = {7'b0, m_user_reg};

endmodule

// ===== hw/rtl/isad_cell.sv =====
// one storage cell of the insertion row: value, valid bit, compare and shift
// depends on isad_pkg
module isad_cell
    import isad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  data_t      key,
    input  data_t      left_val,
    input  logic       left_valid,
    input  logic       left_move,
    input  data_t      right_val,
    input  logic       right_valid,
    input  logic       right_move,
    output data_t      val,
    output logic       valid,
    output logic       move
);

    data_t val_reg;
    data_t val_next;
    logic  valid_reg;
    logic  valid_next;
    logic  after_key;

    // stored entry goes strictly after the key in the chosen order
    assign after_key = ctrl.ascending ? (val_reg > key) : (val_reg < key);

    // this cell takes part in the shift toward the tail
    assign move = (valid_reg ? after_key : 1'b1) & right_move;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.shl)
        begin
            val_next   = right_val;
            valid_next = right_valid;
        end
        else if (ctrl.ins && move)
        begin
            if (left_move)
            begin
                val_next   = left_val;
                valid_next = left_valid;
            end
            else
            begin
                val_next   = key;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

// ===== hw/rtl/isad_checker.sv =====
// port-level checks for insertion_sorter_asc_desc, attached by bind
// depends on isad_pkg
module isad_checker
    import isad_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              s_axis_tlast,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic [7:0]        m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // input closes once a set is complete
    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after end of set");

    // drain runs without gaps and keeps the overflow flag for the whole set
    a_drain_cont: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && $stable(m_axis_tuser))
        else $error("gap or flag change inside an emitted set");

    // no input while a set is still being emitted
    a_no_in_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during emission");

endmodule

bind insertion_sorter_asc_desc isad_checker u_isad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/insertion_sorter_asc_desc_tb.sv =====
// testbench for insertion_sorter_asc_desc: directed and random sets checked against a shadow row
// depends on isad_pkg and the insertion_sorter_asc_desc rtl
`timescale 1ns / 100ps

module insertion_sorter_asc_desc_tb;
    import isad_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        data_t value;
        logic  is_last;
        logic  dropped;
    } sorted_item_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_wr_data = 1'b1;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic [7:0]        m_axis_tuser;

    // shadow of the sorter state
    data_t        shadow_row [CAPACITY];
    int           shadow_fill = 0;
    logic         shadow_dropped = 1'b0;
    logic         shadow_ascending = 1'b1;
    sorted_item_t pending_sorted [$];

    int  mismatches = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;
    bit  src_active = 1'b0;

    insertion_sorter_asc_desc #(.CAPACITY(CAPACITY)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // value
        .s_axis_tlast  (s_axis_tlast),   // last_in
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // sorted_value
        .m_axis_tlast  (m_axis_tlast),   // last_out
        .m_axis_tuser  (m_axis_tuser)    // overflowed, then zeros
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[insertion_sorter_asc_desc] ERROR");
            $finish;
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 19) < 17)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int source_gap();
        if (calm || $urandom_range(0, 9) < 6)
            return 0;
        return idle_len();
    endfunction

    // receiver stalls
    always @(posedge clk)
    begin
        if (!calm && stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = idle_len();
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    // compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        sorted_item_t exp_item;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_sorted.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got value %0d last %0b user %h",
                         $time, $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                exp_item = pending_sorted.pop_front();
                if (m_axis_tdata !== exp_item.value || m_axis_tlast !== exp_item.is_last ||
                    m_axis_tuser !== {7'b0, exp_item.dropped})
                begin
                    $display(
                        "%0t: mismatch, expected %0d last %0b user %h, got %0d last %0b user %h",
                        $time, exp_item.value, exp_item.is_last, {7'b0, exp_item.dropped},
                        $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    function automatic bit ranks_after(data_t stored, data_t key);
        return shadow_ascending ? (stored > key) : (stored < key);
    endfunction

    task automatic shadow_insert(input data_t key, input logic closes_set);
        int           pos;
        sorted_item_t item;
        if (shadow_fill >= CAPACITY)
            shadow_dropped = 1'b1;
        else
        begin
            pos = shadow_fill;
            while (pos > 0 && ranks_after(shadow_row[pos-1], key))
            begin
                shadow_row[pos] = shadow_row[pos-1];
                pos--;
            end
            shadow_row[pos] = key;
            shadow_fill++;
        end
        if (closes_set)
        begin
            for (int i = 0; i < shadow_fill; i++)
            begin
                item.value   = shadow_row[i];
                item.is_last = (i == shadow_fill - 1);
                item.dropped = shadow_dropped;
                pending_sorted.push_back(item);
            end
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    task automatic stop_source();
        if (src_active)
            s_axis_tvalid <= 1'b0;
        src_active = 1'b0;
    endtask

    task automatic send_value(input data_t key, input logic closes_set);
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            stop_source();
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tlast  <= closes_set;
        src_active = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        shadow_insert(key, closes_set);
    endtask

    task automatic wait_drained();
        stop_source();
        while (pending_sorted.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_order(input logic ascending);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ascending;
        @(posedge clk);
        shadow_ascending = ascending;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic data_t random_value();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return data_t'($urandom);
        if (r < 14)
            return data_t'($urandom_range(0, 8)) - 4;
        if (r < 17)
            return ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000)
                   ^ data_t'($urandom_range(0, 3));
        return data_t'($urandom_range(0, 2000)) - 1000;
    endfunction

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++)
            send_value(random_value(), i == len - 1);
    endtask

    task automatic test_ascending_extremes();
        write_order(1'b1);
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h0000_0000, 1'b0);
        send_value(32'hffff_ffff, 1'b0);
        send_value(32'h0000_0001, 1'b0);
        send_value(32'h8000_0000, 1'b1);
    endtask

    task automatic test_descending_extremes();
        write_order(1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'hffff_ffff, 1'b0);
        send_value(32'h0000_0000, 1'b0);
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h5555_aaaa, 1'b1);
    endtask

    task automatic test_single_item();
        send_value(32'haaaa_5555, 1'b1);
    endtask

    // entries stored before the switch keep their place
    task automatic test_order_change_mid_set();
        write_order(1'b1);
        send_value(32'd30, 1'b0);
        send_value(32'd10, 1'b0);
        send_value(32'd20, 1'b0);
        write_order(1'b0);
        send_value(32'd5, 1'b0);
        send_value(32'd25, 1'b0);
        send_value(32'd40, 1'b1);
    endtask

    // exactly full, then overflow with the closing value dropped
    task automatic test_full_store();
        write_order(1'b1);
        send_set(CAPACITY);
        write_order(1'b0);
        send_set(CAPACITY + 2);
    endtask

    task automatic test_random_sets(input int budget);
        int sent;
        int len;
        int split;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 2) == 0)
                write_order(1'($urandom_range(0, 1)));
            calm = ($urandom_range(0, 3) == 0);
            len  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            if (len > 1 && $urandom_range(0, 7) == 0)
            begin
                split = $urandom_range(1, len - 1);
                for (int i = 0; i < split; i++)
                    send_value(random_value(), 1'b0);
                write_order(1'($urandom_range(0, 1)));
                send_set(len - split);
            end
            else
                send_set(len);
            sent += len;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_ascending_extremes();
        test_descending_extremes();
        test_single_item();
        test_order_change_mid_set();
        test_full_store();
        test_random_sets(170);
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[insertion_sorter_asc_desc] OK");
        else
            $display("[insertion_sorter_asc_desc] ERROR");
        $finish;
    end

endmodule
